// ----- design/cicmd_pkg.sv -----
`default_nettype none

package cicmd_pkg;

    // Grid geometry
    localparam int CELLS_X     = 14;
    localparam int CELLS_Y     = 14;
    localparam int CELLS_Z     = 14;
    localparam int GHOST_CELLS = 1;
    localparam int GRID_X      = CELLS_X + 2 * GHOST_CELLS;
    localparam int GRID_Y      = CELLS_Y + 2 * GHOST_CELLS;
    localparam int GRID_Z      = CELLS_Z + 2 * GHOST_CELLS;
    localparam int GRID_TOTAL  = GRID_X * GRID_Y * GRID_Z;
    localparam int ADDR_W      = $clog2(GRID_TOTAL);

    // Field widths
    localparam int CELL_W = 12;
    localparam int DENS_W = 48;
    localparam int FRAC_W = 16;
    localparam int IDX_W  = 35;
    localparam int CFG_W  = 32;

    localparam logic [DENS_W-1:0] DENS_MAX = {DENS_W{1'b1}};

    typedef logic signed [IDX_W-1:0] t_idx;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_DEPOSIT = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Y   = 3'd1,
        CFG_ORIGIN_Z   = 3'd2,
        CFG_INV_CELL_X = 3'd3,
        CFG_INV_CELL_Y = 3'd4,
        CFG_INV_CELL_Z = 3'd5,
        CFG_INV_VOLUME = 3'd6
    } t_cfg_idx;

    // One classified job passed from the front to the back
    typedef struct packed {
        t_op                op;
        logic               oor;
        logic               pm_sat;
        logic [DENS_W-1:0]  pm;
        logic [FRAC_W-1:0]  fx;
        logic [FRAC_W-1:0]  fy;
        logic [FRAC_W-1:0]  fz;
        logic [ADDR_W-1:0]  base;
        logic [CELL_W-1:0]  cell_idx;
    } t_job;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Highest legal lower index on one axis
    function automatic t_idx axis_limit(input logic [1:0] axis);
        t_idx lim;
        case (axis)
            2'd0:    lim = t_idx'(GRID_X - 3);
            2'd1:    lim = t_idx'(GRID_Y - 3);
            default: lim = t_idx'(GRID_Z - 3);
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

// ----- design/cic_mass_deposit_3d_core.sv -----
`default_nettype none

// Cloud-in-cell mass deposit into a 3D density grid with ghost cells.
// Commands are taken on start while busy is low: clear the grid, deposit one
// particle (position, mass) or read one cell. Every command yields exactly
// one result beat on o_done with o_status, o_cell_density and o_base_cell;
// the receiver cannot stall, so each beat is valid for one cycle only.
// Configuration registers (origins, inverse cell sizes, inverse volume) are
// written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them
// only while no command is in flight, which the block itself does not enforce.
// The front maps positions to cells (three steps per axis: difference,
// multiply, sum) and queues the job; the back works on the grid memory.
// A deposit visits the eight corners of its cube in the back, each
// through B_M1, B_M2, B_M3 and B_ADD; a read passes B_READ, a clear writes
// every cell. The front can take the next command while the back works,
// until the two-entry job queue is full. After reset the back clears all
// 4096 cells, one per cycle, with busy high; configuration writes are taken meanwhile.
module cic_mass_deposit_3d_core
    import cicmd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_operation,
    input  wire logic [31:0]        i_pos_x,
    input  wire logic [31:0]        i_pos_y,
    input  wire logic [31:0]        i_pos_z,
    input  wire logic [31:0]        i_mass,
    input  wire logic [CELL_W-1:0]  i_cell_index,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    output logic                    o_done,
    output logic [1:0]              o_status,
    output logic [DENS_W-1:0]       o_cell_density,
    output logic [CELL_W-1:0]       o_base_cell
);

    logic    w_front_busy;
    logic    w_init;
    logic    w_accept;
    logic    w_push;
    logic    w_pop;
    t_job    w_job;
    t_job    w_head;
    t_qstat  w_qstat;

    assign busy     = w_front_busy || w_init;
    assign w_accept = start && !busy;

    // Position mapping and classification
    cicmd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_operation  (i_operation),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_mass       (i_mass),
        .i_cell_index (i_cell_index),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_qstat      (w_qstat),
        .o_busy       (w_front_busy),
        .o_push       (w_push),
        .o_job        (w_job)
    );

    // Job queue between the two sides
    cicmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    // Grid memory and accumulation
    cicmd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_qstat        (w_qstat),
        .o_pop          (w_pop),
        .o_init         (w_init),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_cell_density (o_cell_density),
        .o_base_cell    (o_base_cell)
    );

endmodule

`default_nettype wire

// ----- design/cicmd_front.sv -----
`default_nettype none

module cicmd_front
    import cicmd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [1:0]         i_operation,
    input  wire logic [31:0]        i_pos_x,
    input  wire logic [31:0]        i_pos_y,
    input  wire logic [31:0]        i_pos_z,
    input  wire logic [31:0]        i_mass,
    input  wire logic [CELL_W-1:0]  i_cell_index,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire t_qstat             i_qstat,
    output logic                    o_busy,
    output logic                    o_push,
    output t_job                    o_job
);

    typedef enum logic [5:0] {
        F_IDLE  = 6'b000001,
        F_DIFF  = 6'b000010,
        F_MUL   = 6'b000100,
        F_SUM   = 6'b001000,
        F_CLASS = 6'b010000,
        F_PUSH  = 6'b100000
    } t_fstate;

    t_fstate             r_state;
    logic [31:0]         r_origin [3];
    logic [31:0]         r_inv_cell [3];
    logic [31:0]         r_inv_volume;
    logic [31:0]         r_pos [3];
    logic [31:0]         r_mass;
    logic [1:0]          r_axis;
    logic signed [32:0]  r_diff;
    logic signed [49:0]  r_ph;
    logic signed [49:0]  r_pl;
    logic [63:0]         r_pm64;
    t_idx                r_idx [3];
    logic [FRAC_W-1:0]   r_frac [3];
    t_job                r_job;

    logic signed [50:0]  w_u;
    t_idx                w_uidx;
    logic                w_oor;
    logic [ADDR_W-1:0]   w_xl, w_yl, w_zl;
    logic [31:0]         w_inv;

    // Cell coordinate u = diff*inv in Q.16, shifted back by half a cell
    assign w_inv  = r_inv_cell[r_axis];
    assign w_u    = 51'(r_ph) + 51'(r_pl >>> 16) - 51'sd32768;
    assign w_uidx = t_idx'(w_u >>> 16);

    // Range check on all three axes
    always_comb begin
        w_oor = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (r_idx[a] < -t_idx'(1) || r_idx[a] > axis_limit(2'(a))) begin
                w_oor = 1'b1;
            end
        end
    end

    // Lower corner coordinates with the ghost offset added
    assign w_xl = ADDR_W'(r_idx[0] + t_idx'(GHOST_CELLS));
    assign w_yl = ADDR_W'(r_idx[1] + t_idx'(GHOST_CELLS));
    assign w_zl = ADDR_W'(r_idx[2] + t_idx'(GHOST_CELLS));

    assign o_busy = (r_state != F_IDLE);
    assign o_push = (r_state == F_PUSH) && !i_qstat.full;
    assign o_job  = r_job;

    // Configuration registers and front sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= F_IDLE;
            r_origin[0]   <= '0;
            r_origin[1]   <= '0;
            r_origin[2]   <= '0;
            r_inv_cell[0] <= 32'd65536;
            r_inv_cell[1] <= 32'd65536;
            r_inv_cell[2] <= 32'd65536;
            r_inv_volume  <= 32'd65536;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ORIGIN_X:   r_origin[0]   <= i_cfg_data;
                    CFG_ORIGIN_Y:   r_origin[1]   <= i_cfg_data;
                    CFG_ORIGIN_Z:   r_origin[2]   <= i_cfg_data;
                    CFG_INV_CELL_X: r_inv_cell[0] <= i_cfg_data;
                    CFG_INV_CELL_Y: r_inv_cell[1] <= i_cfg_data;
                    CFG_INV_CELL_Z: r_inv_cell[2] <= i_cfg_data;
                    CFG_INV_VOLUME: r_inv_volume  <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                F_IDLE: begin
                    if (i_accept) begin
                        r_pos[0]    <= i_pos_x;
                        r_pos[1]    <= i_pos_y;
                        r_pos[2]    <= i_pos_z;
                        r_mass      <= i_mass;
                        r_axis      <= 2'd0;
                        r_job       <= '{op: t_op'(i_operation), cell_idx: i_cell_index,
                                         default: '0};
                        if (t_op'(i_operation) == OP_DEPOSIT) begin
                            r_state <= F_DIFF;
                        end else begin
                            r_state <= F_PUSH;
                        end
                    end
                end
                F_DIFF: begin
                    r_diff  <= $signed({r_pos[r_axis][31], r_pos[r_axis]})
                             - $signed({r_origin[r_axis][31], r_origin[r_axis]});
                    r_state <= F_MUL;
                end
                F_MUL: begin
                    r_ph    <= r_diff * $signed({1'b0, w_inv[31:16]});
                    r_pl    <= r_diff * $signed({1'b0, w_inv[15:0]});
                    r_pm64  <= r_mass * r_inv_volume;
                    r_state <= F_SUM;
                end
                F_SUM: begin
                    r_idx[r_axis]  <= w_uidx;
                    r_frac[r_axis] <= w_u[FRAC_W-1:0];
                    if (r_axis == 2'd2) begin
                        r_state <= F_CLASS;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= F_DIFF;
                    end
                end
                F_CLASS: begin
                    r_job.oor    <= w_oor;
                    r_job.pm_sat <= (r_pm64[63:DENS_W] != '0);
                    r_job.pm     <= (r_pm64[63:DENS_W] != '0) ? DENS_MAX
                                                              : r_pm64[DENS_W-1:0];
                    r_job.fx     <= r_frac[0];
                    r_job.fy     <= r_frac[1];
                    r_job.fz     <= r_frac[2];
                    r_job.base   <= w_xl + ADDR_W'(w_yl * ADDR_W'(GRID_X))
                                  + ADDR_W'(w_zl * ADDR_W'(GRID_X * GRID_Y));
                    r_state      <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_qstat.full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/cicmd_queue.sv -----
`default_nettype none

module cicmd_queue
    import cicmd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_job  i_job,
    input  wire logic  i_pop,
    output t_job       o_head,
    output t_qstat     o_qstat
);

    t_job        r_slot [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;

    assign o_head        = r_slot[r_rptr];
    assign o_qstat.full  = (r_count == 2'd2);
    assign o_qstat.empty = (r_count == 2'd0);

    // Two-entry ring of jobs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_slot[r_wptr] <= i_job;
                r_wptr         <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_qstat.full |-> !i_push || i_pop)
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_qstat.empty)
        else $error("job queue underflow");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop && !o_qstat.full) |=> !o_qstat.empty)
        else $error("job queue lost a beat");
`endif

endmodule

`default_nettype wire

// ----- design/cicmd_back.sv -----
`default_nettype none

module cicmd_back
    import cicmd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_job               i_head,
    input  wire t_qstat             i_qstat,
    output logic                    o_pop,
    output logic                    o_init,
    output logic                    o_done,
    output logic [1:0]              o_status,
    output logic [DENS_W-1:0]       o_cell_density,
    output logic [CELL_W-1:0]       o_base_cell
);

    typedef enum logic [7:0] {
        B_INIT  = 8'b00000001,
        B_IDLE  = 8'b00000010,
        B_CLEAR = 8'b00000100,
        B_READ  = 8'b00001000,
        B_M1    = 8'b00010000,
        B_M2    = 8'b00100000,
        B_M3    = 8'b01000000,
        B_ADD   = 8'b10000000
    } t_bstate;

    t_bstate            r_state;
    t_job               r_cur;
    logic [ADDR_W-1:0]  r_cnt;
    logic [2:0]         r_corner;
    logic [DENS_W-1:0]  r_t;
    logic               r_sat;
    logic               r_done;
    t_status            r_status;
    logic [DENS_W-1:0]  r_dens;
    logic [CELL_W-1:0]  r_base;
    logic [DENS_W-1:0]  r_mem [GRID_TOTAL];
    logic [DENS_W-1:0]  r_rdata;

    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [DENS_W-1:0]  w_wdata;
    logic [ADDR_W-1:0]  w_raddr;
    logic [ADDR_W-1:0]  w_caddr;
    logic [DENS_W-1:0]  w_mul_a;
    logic [16:0]        w_mul_b;
    logic [64:0]        w_prod;
    logic [DENS_W:0]    w_sum;
    logic [FRAC_W-1:0]  w_frac;
    logic               w_hi;
    logic               w_head_read_ok;
    logic               w_last_cell;

    assign w_head_read_ok = (32'(i_head.cell_idx) < 32'(GRID_TOTAL));
    assign w_last_cell    = (r_cnt == ADDR_W'(GRID_TOTAL - 1));

    // Address of the current corner of the deposit cube
    assign w_caddr = r_cur.base + ADDR_W'(r_corner[0])
                   + (r_corner[1] ? ADDR_W'(GRID_X) : '0)
                   + (r_corner[2] ? ADDR_W'(GRID_X * GRID_Y) : '0);

    // Shared weight multiplier: x, then y, then z weight
    always_comb begin
        case (r_state)
            B_M1: begin
                w_frac = r_cur.fx;
                w_hi   = r_corner[0];
            end
            B_M2: begin
                w_frac = r_cur.fy;
                w_hi   = r_corner[1];
            end
            default: begin
                w_frac = r_cur.fz;
                w_hi   = r_corner[2];
            end
        endcase
    end
    assign w_mul_a = (r_state == B_M1) ? r_cur.pm : r_t;
    assign w_mul_b = w_hi ? {1'b0, w_frac} : (17'd65536 - {1'b0, w_frac});
    assign w_prod  = 65'(w_mul_a) * 65'(w_mul_b);

    // Saturating accumulate
    assign w_sum = {1'b0, r_rdata} + {1'b0, r_t};

    // Memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt;
        w_wdata = '0;
        w_raddr = w_caddr;
        case (r_state)
            B_INIT, B_CLEAR: w_we = 1'b1;
            B_IDLE: w_raddr = ADDR_W'(i_head.cell_idx);
            B_ADD: begin
                w_we    = 1'b1;
                w_waddr = w_caddr;
                w_wdata = w_sum[DENS_W] ? DENS_MAX : w_sum[DENS_W-1:0];
            end
            default: ;
        endcase
    end

    // Grid memory, one write port and one read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_pop          = (r_state == B_IDLE) && !i_qstat.empty;
    assign o_init         = (r_state == B_INIT);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_cell_density = r_dens;
    assign o_base_cell    = r_base;

    // Back sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_INIT;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                B_INIT: begin
                    r_cnt <= r_cnt + ADDR_W'(1);
                    if (w_last_cell) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_cur    <= i_head;
                        r_cnt    <= '0;
                        r_corner <= 3'd0;
                        r_sat    <= i_head.pm_sat;
                        r_status <= ST_DONE;
                        r_dens   <= '0;
                        r_base   <= '0;
                        case (i_head.op)
                            OP_CLEAR: r_state <= B_CLEAR;
                            OP_READ: begin
                                if (w_head_read_ok) begin
                                    r_state <= B_READ;
                                end else begin
                                    r_done <= 1'b1;
                                end
                            end
                            OP_DEPOSIT: begin
                                if (i_head.oor) begin
                                    r_status <= ST_RANGE;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state <= B_M1;
                                end
                            end
                            default: r_done <= 1'b1;
                        endcase
                    end
                end
                B_CLEAR: begin
                    r_cnt <= r_cnt + ADDR_W'(1);
                    if (w_last_cell) begin
                        r_done  <= 1'b1;
                        r_state <= B_IDLE;
                    end
                end
                B_READ: begin
                    r_dens  <= r_rdata;
                    r_done  <= 1'b1;
                    r_state <= B_IDLE;
                end
                B_M1: begin
                    r_t     <= w_prod[DENS_W+15:16];
                    r_state <= B_M2;
                end
                B_M2: begin
                    r_t     <= w_prod[DENS_W+15:16];
                    r_state <= B_M3;
                end
                B_M3: begin
                    r_t     <= w_prod[DENS_W+15:16];
                    r_state <= B_ADD;
                end
                B_ADD: begin
                    if (w_sum[DENS_W]) begin
                        r_sat <= 1'b1;
                    end
                    if (r_corner == 3'd7) begin
                        r_status <= (r_sat || w_sum[DENS_W]) ? ST_SAT : ST_DONE;
                        r_base   <= CELL_W'(r_cur.base);
                        r_done   <= 1'b1;
                        r_state  <= B_IDLE;
                    end else begin
                        r_corner <= r_corner + 3'd1;
                        r_state  <= B_M1;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_result_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_INIT) |-> !r_done)
        else $error("result during clearing pass");
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_READ) |=> r_done)
        else $error("read beat missing");
    a_deposit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_ADD && r_corner == 3'd7) |=> r_done && r_status != ST_RANGE)
        else $error("deposit beat missing");
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR && w_last_cell) |=> r_done && r_status == ST_DONE)
        else $error("clear beat missing");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/cic_mass_deposit_3d_core_tb.sv -----
`timescale 1ns / 100ps

module cic_mass_deposit_3d_core_tb;
    import cicmd_pkg::*;

    typedef struct {
        t_op               op;
        logic [31:0]       px;
        logic [31:0]       py;
        logic [31:0]       pz;
        logic [31:0]       mass;
        logic [CELL_W-1:0] cell_idx;
    } cmd_t;

    typedef struct {
        logic [1:0]        status;
        logic [DENS_W-1:0] dens;
        logic [CELL_W-1:0] base;
    } beat_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_operation = '0;
    logic [31:0]       i_pos_x = '0;
    logic [31:0]       i_pos_y = '0;
    logic [31:0]       i_pos_z = '0;
    logic [31:0]       i_mass = '0;
    logic [CELL_W-1:0] i_cell_index = '0;
    logic              i_cfg_we = 1'b0;
    logic [2:0]        i_cfg_idx = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              o_done;
    logic [1:0]        o_status;
    logic [DENS_W-1:0] o_cell_density;
    logic [CELL_W-1:0] o_base_cell;

    cic_mass_deposit_3d_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_mass         (i_mass),
        .i_cell_index   (i_cell_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_cell_density (o_cell_density),
        .o_base_cell    (o_base_cell)
    );

    // Shadow copy of the block's registers and grid.
    logic [31:0]       shadow_cfg [7];
    logic [DENS_W-1:0] shadow_grid [GRID_TOTAL];

    cmd_t  pending_cmds [$];
    beat_t awaited_beats [$];
    cmd_t  cmd_on_port;
    int    send_idle_pct = 25;
    int    fail_count = 0;

    // Clock and reset.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // Maps one coordinate to its lower cell index, with the Q0.16 fraction.
    function automatic longint cell_of_axis(input logic [31:0] pos, input logic [31:0] org,
                                            input logic [31:0] inv, output logic [15:0] frac);
        longint diff;
        longint u;
        diff = longint'($signed(pos)) - longint'($signed(org));
        u = diff * longint'(inv[31:16]) + ((diff * longint'(inv[15:0])) >>> 16) - 32768;
        frac = u[15:0];
        return u >>> 16;
    endfunction

    // Applies one command to the shadow grid and returns the beat it yields.
    function automatic beat_t apply_command(input cmd_t c);
        beat_t       r;
        longint      ix, iy, iz;
        logic [15:0] fx, fy, fz;
        logic [63:0] pm, t, s;
        logic [63:0] wx [2], wy [2], wz [2];
        int          b, n;
        bit          sat;
        r = '{status: ST_DONE, dens: '0, base: '0};
        case (c.op)
            OP_CLEAR: begin
                foreach (shadow_grid[k]) shadow_grid[k] = '0;
            end
            OP_READ: begin
                if (c.cell_idx < GRID_TOTAL) r.dens = shadow_grid[c.cell_idx];
            end
            OP_DEPOSIT: begin
                ix = cell_of_axis(c.px, shadow_cfg[CFG_ORIGIN_X], shadow_cfg[CFG_INV_CELL_X], fx);
                iy = cell_of_axis(c.py, shadow_cfg[CFG_ORIGIN_Y], shadow_cfg[CFG_INV_CELL_Y], fy);
                iz = cell_of_axis(c.pz, shadow_cfg[CFG_ORIGIN_Z], shadow_cfg[CFG_INV_CELL_Z], fz);
                if (ix < -1 || iy < -1 || iz < -1 ||
                    ix > GRID_X - 3 || iy > GRID_Y - 3 || iz > GRID_Z - 3) begin
                    r.status = ST_RANGE;
                end else begin
                    sat = 1'b0;
                    pm = {32'b0, c.mass} * {32'b0, shadow_cfg[CFG_INV_VOLUME]};
                    if (pm > {16'b0, DENS_MAX}) begin
                        pm = {16'b0, DENS_MAX};
                        sat = 1'b1;
                    end
                    wx[0] = 64'd65536 - fx; wx[1] = {48'b0, fx};
                    wy[0] = 64'd65536 - fy; wy[1] = {48'b0, fy};
                    wz[0] = 64'd65536 - fz; wz[1] = {48'b0, fz};
                    b = int'(ix + GHOST_CELLS) + int'(iy + GHOST_CELLS) * GRID_X +
                        int'(iz + GHOST_CELLS) * GRID_X * GRID_Y;
                    // Products wrap at 64 bits before each shift.
                    for (int d = 0; d < 2; d++)
                        for (int e = 0; e < 2; e++)
                            for (int a = 0; a < 2; a++) begin
                                t = (pm * wx[a]) >> 16;
                                t = (t * wy[e]) >> 16;
                                t = (t * wz[d]) >> 16;
                                n = b + a + e * GRID_X + d * GRID_X * GRID_Y;
                                s = {16'b0, shadow_grid[n]} + t;
                                if (s > {16'b0, DENS_MAX}) begin
                                    shadow_grid[n] = DENS_MAX;
                                    sat = 1'b1;
                                end else begin
                                    shadow_grid[n] = s[DENS_W-1:0];
                                end
                            end
                    r.base = b[CELL_W-1:0];
                    if (sat) r.status = ST_SAT;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Command driver: a beat is taken when start is high and busy is low.
    always @(posedge i_clk) begin
        cmd_t c;
        if (start && !busy) awaited_beats.push_back(apply_command(cmd_on_port));
        if (!start || !busy) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                c = pending_cmds.pop_front();
                cmd_on_port  <= c;
                i_operation  <= c.op;
                i_pos_x      <= c.px;
                i_pos_y      <= c.py;
                i_pos_z      <= c.pz;
                i_mass       <= c.mass;
                i_cell_index <= c.cell_idx;
                start        <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        beat_t w;
        if (i_rst_n && o_done) begin
            if (awaited_beats.size() == 0) begin
                note_mismatch("unexpected result beat", o_status, 0);
            end else begin
                w = awaited_beats.pop_front();
                if (o_status !== w.status) note_mismatch("status", o_status, w.status);
                if (o_cell_density !== w.dens)
                    note_mismatch("cell_density", o_cell_density, w.dens);
                if (o_base_cell !== w.base) note_mismatch("base_cell", o_base_cell, w.base);
            end
        end
    end

    task automatic write_regs(input logic [31:0] vals [7]);
        for (int r = 0; r < 7; r++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(r);
            i_cfg_data <= vals[r];
            shadow_cfg[r] = vals[r];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain;
        while (pending_cmds.size() > 0 || start || awaited_beats.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic cmd_t make_cmd(input t_op op, input logic [31:0] px,
                                      input logic [31:0] py, input logic [31:0] pz,
                                      input logic [31:0] mass, input int cell_no);
        cmd_t c;
        c.op = op; c.px = px; c.py = py; c.pz = pz; c.mass = mass;
        c.cell_idx = cell_no[CELL_W-1:0];
        return c;
    endfunction

    // Position that lands near a chosen Q16.16 coordinate in cell units.
    function automatic logic [31:0] aim_axis(input int r);
        longint p;
        int     cu;
        if (shadow_cfg[CFG_INV_CELL_X + r] == 0) return $urandom;
        cu = int'($urandom_range(0, 16 * 65536 + 20000)) - 50000;
        p = longint'($signed(shadow_cfg[CFG_ORIGIN_X + r])) +
            (longint'(cu) <<< 16) / longint'(shadow_cfg[CFG_INV_CELL_X + r]);
        return p[31:0];
    endfunction

    function automatic cmd_t random_cmd;
        int   pick;
        cmd_t c;
        pick = $urandom_range(99);
        c = make_cmd(OP_DEPOSIT, $urandom, $urandom, $urandom, $urandom, $urandom_range(4095));
        if ($urandom_range(2) == 0) c.mass = $urandom_range(1 << 20);
        if (pick < 2) begin
            c.op = OP_CLEAR;
        end else if (pick < 27) begin
            c.op = OP_READ;
        end else if (pick < 32) begin
            c.op = OP_NONE;
        end else if (pick < 85) begin
            c.px = aim_axis(0);
            c.py = aim_axis(1);
            c.pz = aim_axis(2);
        end else if (pick < 92) begin
            // One axis off its cube, the others aimed.
            c.px = aim_axis(0);
            c.py = aim_axis(1);
            c.pz = aim_axis(2);
            case ($urandom_range(2))
                0: c.px = $urandom;
                1: c.py = $urandom;
                default: c.pz = $urandom;
            endcase
        end
        return c;
    endfunction

    // Stimulus: directed commands, then random phases under several settings.
    initial begin
        logic [31:0] regs [7];
        regs = '{32'd0, 32'd0, 32'd0, 32'd65536, 32'd65536, 32'd65536, 32'd65536};
        foreach (shadow_cfg[r]) shadow_cfg[r] = regs[r];
        foreach (shadow_grid[k]) shadow_grid[k] = '0;
        @(posedge i_clk);
        write_regs(regs);

        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0));
        // Corner at the lowest legal index on all axes.
        pending_cmds.push_back(make_cmd(OP_DEPOSIT, 32'hFFFF_8000, 32'hFFFF_8000,
                                        32'hFFFF_8000, 32'h0001_0000, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0));
        // Just below the lowest index, per axis.
        pending_cmds.push_back(make_cmd(OP_DEPOSIT, 32'hFFFF_7FFF, 0, 0, 32'h0001_0000, 0));
        pending_cmds.push_back(make_cmd(OP_DEPOSIT, 0, 32'hFFFF_7FFF, 0, 32'h0001_0000, 0));
        pending_cmds.push_back(make_cmd(OP_DEPOSIT, 0, 0, 32'hFFFF_7FFF, 32'h0001_0000, 0));
        // Top legal index, then one past it, per axis.
        pending_cmds.push_back(make_cmd(OP_DEPOSIT, 32'h000E_7FFF, 32'h000E_7FFF,
                                        32'h000E_7FFF, 32'hFFFF_FFFF, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, GRID_TOTAL - 1));
        pending_cmds.push_back(make_cmd(OP_DEPOSIT, 32'h000E_8000, 0, 0, 32'h0001_0000, 0));
        pending_cmds.push_back(make_cmd(OP_DEPOSIT, 0, 32'h000E_8000, 0, 32'h0001_0000, 0));
        pending_cmds.push_back(make_cmd(OP_DEPOSIT, 0, 0, 32'h000E_8000, 32'h0001_0000, 0));
        // Extreme positions and a cell hit until its sum clamps.
        pending_cmds.push_back(make_cmd(OP_DEPOSIT, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h8000_0000, 32'hFFFF_FFFF, 0));
        for (int k = 0; k < 3; k++)
            pending_cmds.push_back(make_cmd(OP_DEPOSIT, 32'h0003_8000, 32'h0003_8000,
                                            32'h0003_8000, 32'hFFFF_FFFF, 4095));
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 3 + 3 * 16 + 3 * 256 + 273));
        pending_cmds.push_back(make_cmd(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 4095));
        pending_cmds.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 273));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 25 : (ph < 4) ? 65 : 0;
            case (ph)
                0: regs = '{$urandom, $urandom, $urandom, 32'h0002_0000, 32'h0000_8000,
                            32'h0001_8000, 32'h0000_0001};
                1: regs = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'd0, 32'd1, 32'hFFFF_FFFF};
                2: regs = '{$urandom, $urandom, $urandom, $urandom_range(32'h8000, 32'h40000),
                            $urandom_range(32'h8000, 32'h40000),
                            $urandom_range(32'h8000, 32'h40000), 32'd0};
                3: regs = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom};
                4: regs = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_0000,
                            32'h0000_FFFF, 32'h0001_0000, $urandom};
                default: regs = '{32'd0, 32'd0, 32'd0, 32'd65536, 32'd65536, 32'd65536,
                                  32'd65536};
            endcase
            write_regs(regs);
            for (int k = 0; k < 155; k++) pending_cmds.push_back(random_cmd());
            drain();
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #400_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
